/* sv/seek_table_floor_search_unit_macros.svh */
// seek_table_floor_search_unit_macros.svh: assertion macros for the seek table search unit
// expects a clock named aclk and an active-low synchronous reset named aresetn in scope
// no other dependencies
`ifndef SEEK_TABLE_FLOOR_SEARCH_UNIT_MACROS_SVH
`define SEEK_TABLE_FLOOR_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define STFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/stfs_pkg.sv */
// stfs_pkg: beat types and codes of the seek table search unit
// shared by stfs_ctrl and seek_table_floor_search_unit; no dependencies
package stfs_pkg;

    // item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam int POS_W     = 64;
    localparam int OUT_IDX_W = 12;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] point_position;
        logic [POS_W-1:0] target_sample;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] point_index;
        logic                 exact_hit;
    } out_beat_t;

endpackage

/* sv/stfs_ram.sv */
// stfs_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module stfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/stfs_ctrl.sv */
// stfs_ctrl: point count, item sequencer and binary search over the seek table ram
// depends on stfs_pkg; drives the ports of one stfs_ram
module stfs_ctrl
    import stfs_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  in_beat_t                      in_beat,
    output logic                          res_valid,
    input  logic                          res_take,
    output out_beat_t                     res_beat,
    output logic                          ram_we,
    output logic [$clog2(MAX_POINTS)-1:0] ram_waddr,
    output logic [POS_W-1:0]              ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(MAX_POINTS)-1:0] ram_raddr,
    input  logic [POS_W-1:0]              ram_rdata
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]    mid_reg, mid_next;
    logic [POS_W-1:0] target_reg, target_next;
    out_beat_t        res_reg, res_next;

    logic             accept;
    logic             has_room;
    logic [CW-1:0]    mid_first;
    logic             probe_eq;
    logic             probe_lt;
    logic [CW-1:0]    lo_upd;
    logic [CW-1:0]    hi_upd;
    logic [CW-1:0]    mid_upd;
    logic [CW-1:0]    floor_idx;

    // widen or mask a table index to the result index width
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [AW-1:0] idx);
        logic [AW+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign has_room  = (count_reg < CW'(MAX_POINTS));
    assign res_valid = (state_reg == ST_DONE);
    assign res_beat  = res_reg;

    // probe arithmetic: compare against the entry read last cycle, narrow the range
    assign mid_first = count_reg >> 1;
    assign probe_eq  = (target_reg == ram_rdata);
    assign probe_lt  = (target_reg < ram_rdata);
    assign lo_upd    = probe_lt ? lo_reg : CW'(mid_reg) + CW'(1);
    assign hi_upd    = probe_lt ? CW'(mid_reg) : hi_reg;
    assign mid_upd   = lo_upd + ((hi_upd - lo_upd) >> 1);
    assign floor_idx = lo_upd - CW'(1);

    // append goes straight into the table
    assign ram_we    = accept && (in_beat.kind == KIND_APPEND) && has_room;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = in_beat.point_position;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        target_next = target_reg;
        res_next    = res_reg;
        ram_re      = 1'b0;
        ram_raddr   = mid_first[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next    = '{status: STATUS_OK, point_index: '0, exact_hit: 1'b0};
                    state_next  = ST_DONE;
                    target_next = in_beat.target_sample;
                    priority if (in_beat.kind == KIND_CLEAR) begin
                        count_next = '0;
                    end else if (in_beat.kind == KIND_APPEND) begin
                        if (has_room) begin
                            count_next = count_reg + CW'(1);
                        end else begin
                            res_next.status = STATUS_FULL;
                        end
                    end else if (in_beat.kind == KIND_LOOKUP) begin
                        if (count_reg == '0) begin
                            res_next.status = STATUS_NOT_FOUND;
                        end else begin
                            // first probe at the middle of the whole table
                            ram_re     = 1'b1;
                            lo_next    = '0;
                            hi_next    = count_reg;
                            mid_next   = mid_first[AW-1:0];
                            state_next = ST_PROBE;
                        end
                    end else begin
                        // unused kind leaves the table alone
                        res_next.status = STATUS_OK;
                    end
                end
            end
            ST_PROBE: begin
                priority if (probe_eq) begin
                    res_next   = '{status: STATUS_OK, point_index: to_out_idx(mid_reg),
                                   exact_hit: 1'b1};
                    state_next = ST_DONE;
                end else if (lo_upd < hi_upd) begin
                    // issue the next probe in the same cycle
                    ram_re     = 1'b1;
                    ram_raddr  = mid_upd[AW-1:0];
                    lo_next    = lo_upd;
                    hi_next    = hi_upd;
                    mid_next   = mid_upd[AW-1:0];
                end else if (lo_upd == '0 || lo_upd >= count_reg) begin
                    res_next   = '{status: STATUS_NOT_FOUND, point_index: '0, exact_hit: 1'b0};
                    state_next = ST_DONE;
                end else begin
                    res_next   = '{status: STATUS_OK, point_index: to_out_idx(floor_idx[AW-1:0]),
                                   exact_hit: 1'b0};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // search and result registers
    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        target_reg <= target_next;
        res_reg    <= res_next;
    end

endmodule

/* sv/seek_table_floor_search_unit.sv */
// seek_table_floor_search_unit: top level of the seek table with floor search
// depends on stfs_pkg, stfs_ram, stfs_ctrl and seek_table_floor_search_unit_macros.svh
//
// Holds up to MAX_POINTS ascending 64-bit seek positions in one synchronous ram
// and answers one beat at a time. Clear and append beats load the result
// register directly on acceptance. A lookup probes the table once per cycle
// through the ram's single read port (registered read, next address computed
// from the returned entry), making at most ceil(log2(count + 1)) probes and
// stopping early on an exact hit. A new beat is taken once the previous one has
// moved to the output register, which holds the result until m_ready; there is
// no clearing pass after reset, since only written entries are ever read.
`include "seek_table_floor_search_unit_macros.svh"

module seek_table_floor_search_unit
    import stfs_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int AW = $clog2(MAX_POINTS);

    logic             res_valid;
    logic             res_take;
    out_beat_t        res_beat;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [POS_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [POS_W-1:0] ram_rdata;

    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;

    // seek position table
    stfs_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer and search
    stfs_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_beat  (res_beat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register: loads when empty or being drained
    assign res_take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_take) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_beat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `STFS_ASSERT_NOW(a_idle_xor_done, res_valid, !s_ready, "result pending while accepting")
    `STFS_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "beat taken while busy")
    `STFS_ASSERT_NEXT(a_result_lands, res_valid && res_take, m_valid, "result lost at output")
    `STFS_ASSERT_NOW(a_miss_is_clean, m_valid && m_data.status != STATUS_OK,
                     m_data.point_index == '0 && !m_data.exact_hit, "miss carries an index")

endmodule
